// File: rtl/core/ip_fragment_tunnel_classifier_defines.svh
// Assertion macros used by the checker.
`ifndef IP_FRAGMENT_TUNNEL_CLASSIFIER_DEFINES_SVH
`define IP_FRAGMENT_TUNNEL_CLASSIFIER_DEFINES_SVH

// Clocked assertion, disabled while the active-low reset is asserted.
`define IPFTC_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Same, with the clock and reset names fixed to the top-level ports.
`define IPFTC_ASSERT_TOP(lbl, prop, msg) \
    `IPFTC_ASSERT(lbl, i_clk, i_rst_n, prop, msg)

`endif

// File: rtl/core/ipftc_pkg.sv
`timescale 1ns / 1ps
package ipftc_pkg;

    localparam int SLOTS  = 16;
    localparam int SLOT_W = $clog2(SLOTS);

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_EXPORT_EN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EXPORT_IP = 2'd1;

    localparam logic [7:0]  ETH_TAG_HI   = 8'h81;
    localparam logic [7:0]  ETH_MPLS_HI  = 8'h88;
    localparam logic [7:0]  ETH_MPLS_LO  = 8'h47;
    localparam logic [7:0]  PROTO_GRE    = 8'd47;
    localparam logic [7:0]  PROTO_UDP    = 8'd17;
    localparam logic [15:0] VXLAN_PORT   = 16'd4789;
    localparam logic [15:0] FRAG_OFF_MSK = 16'h1FFF;
    localparam logic [15:0] FRAG_MORE    = 16'h2000;

    typedef enum logic [1:0] {
        TAG_NONE = 2'd0,
        TAG_VLAN = 2'd1,
        TAG_MPLS = 2'd2
    } t_tag_mode;

    typedef enum logic [2:0] {
        VERD_PASS   = 3'd0,
        VERD_SELF   = 3'd1,
        VERD_STORED = 3'd2,
        VERD_APPEND = 3'd3,
        VERD_REASM  = 3'd4
    } t_verdict;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_CMP,
        S_MISS,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in;

    typedef struct packed {
        t_verdict    verdict;
        logic [15:0] strip_offset;
        logic [3:0]  slot_index;
        logic [15:0] payload_start;
        logic [15:0] total_length;
    } t_out;

    typedef struct packed {
        logic [15:0] pos;
        logic [3:0]  shift;
        logic [11:0] vlan;
        logic [7:0]  proto;
        logic [15:0] ident;
        logic [31:0] src;
        logic [31:0] dst;
        logic [3:0]  hw;
        logic [15:0] frag;
        logic [15:0] udp;
    } t_frame;

    typedef struct packed {
        logic [31:0] src;
        logic [31:0] dst;
        logic [27:0] key;
        logic [15:0] len;
        logic [15:0] start;
    } t_entry;

endpackage

// File: rtl/core/ipftc_parse.sv
`timescale 1ns / 1ps
module ipftc_parse (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_take,
    input  ipftc_pkg::t_in  i_in,
    output ipftc_pkg::t_frame o_frame
);
    import ipftc_pkg::*;

    t_frame    r_f, n_f, n_adv;
    t_tag_mode r_mode, n_mode;
    logic [7:0] r_held, n_held;
    logic [15:0] p;
    logic [7:0]  b;
    logic [4:0]  base;
    logic [15:0] rel;
    logic [16:0] t;

    always_comb begin
        p      = r_f.pos;
        b      = i_in.data_byte;
        n_f    = r_f;
        n_mode = r_mode;
        n_held = r_held;
        if (p == 16'd12) n_held = b;
        if (p == 16'd13) begin
            if (r_held == ETH_TAG_HI && b == 8'h00) begin
                n_mode = TAG_VLAN;
                n_f.shift = 4'd4;
            end
            if (r_held == ETH_MPLS_HI && b == ETH_MPLS_LO) begin
                n_mode = TAG_MPLS;
                n_f.shift = 4'd4;
            end
        end
        if (n_mode == TAG_VLAN) begin
            if (p == 16'd14) n_f.vlan = {b[3:0], 8'h00};
            if (p == 16'd15) n_f.vlan = {r_f.vlan[11:8], b};
            if (p == 16'd16) n_held = b;
            if (p == 16'd17 && r_held == ETH_TAG_HI && b == 8'h00) n_f.shift = 4'd8;
        end
        if (n_mode == TAG_MPLS && p == 16'd16 && !b[0]) n_f.shift = 4'd8;

        base = 5'd14 + {1'b0, n_f.shift};
        rel  = p - {11'd0, base};
        t    = {12'd0, base} + {11'd0, r_f.hw, 2'b00} + {1'b0, r_f.frag & FRAG_OFF_MSK};
        if (p >= {11'd0, base}) begin
            if (rel == 16'd0) n_f.hw = b[3:0];
            else if (rel == 16'd4) n_f.ident = {b, r_f.ident[7:0]};
            else if (rel == 16'd5) n_f.ident = {r_f.ident[15:8], b};
            else if (rel == 16'd6) n_f.frag = {b, r_f.frag[7:0]};
            else if (rel == 16'd7) n_f.frag = {r_f.frag[15:8], b};
            else if (rel == 16'd9) n_f.proto = b;
            else if (rel >= 16'd12 && rel <= 16'd15) n_f.src = {r_f.src[23:0], b};
            else if (rel >= 16'd16 && rel <= 16'd19) n_f.dst = {r_f.dst[23:0], b};
            if (rel > 16'd7) begin
                if ({1'b0, p} == t + 17'd2) n_f.udp = {b, r_f.udp[7:0]};
                if ({1'b0, p} == t + 17'd3) n_f.udp = {r_f.udp[15:8], b};
            end
        end
        n_adv     = n_f;
        n_adv.pos = (r_f.pos == 16'hFFFF) ? r_f.pos : r_f.pos + 16'd1;
    end

    assign o_frame = n_f;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f    <= '0;
            r_mode <= TAG_NONE;
            r_held <= '0;
        end else if (i_take) begin
            if (i_in.last_byte) begin
                r_f    <= '0;
                r_mode <= TAG_NONE;
                r_held <= '0;
            end else begin
                r_f     <= n_adv;
                r_mode  <= n_mode;
                r_held  <= n_held;
            end
        end
    end

endmodule

// File: rtl/core/ip_fragment_tunnel_classifier.sv
`timescale 1ns / 1ps
// Channel | Direction | Payload              | Handshake
// in      | input     | t_in  (byte, last)   | i_in_valid / o_in_ready
// out     | output    | t_out (one per frame)| o_out_valid / i_out_ready
// cfg     | input     | index, 32-bit data   | i_cfg_valid / o_cfg_ready
//
// Header bytes are taken one per cycle. After the last byte the slot table
// is scanned, one read and one compare step per slot, and no byte is taken until
// the result is handed to the output register; this waits while the previous
// result still waits at the output.
// The result register lets the next frame's bytes flow while a result waits.
// Reset is synchronous; it clears the slot valid bits at once, no clearing pass.
module ip_fragment_tunnel_classifier (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  ipftc_pkg::t_in                      i_in,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output ipftc_pkg::t_out                     o_out,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [ipftc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [31:0]                         i_cfg_data
);
    import ipftc_pkg::*;

    t_state r_state, n_state;
    t_frame w_frame, r_frm;
    logic   w_take;

    logic        r_exp_en;
    logic [31:0] r_exp_ip;

    t_entry r_mem [SLOTS];
    t_entry r_rd;
    logic [SLOTS-1:0] r_valid;
    logic [SLOT_W-1:0] r_idx, r_free;
    logic r_free_ok;

    t_out r_res, c_res;
    logic c_wr;
    logic [SLOT_W-1:0] c_waddr;
    t_entry c_wdata;
    logic c_hit, c_last, c_self, c_more, c_drop;

    logic [15:0] flen, head, off, add, start;
    logic [27:0] key;
    logic [16:0] sum;

    assign w_take      = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;

    ipftc_parse u_parse (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (w_take),
        .i_in    (i_in),
        .o_frame (w_frame)
    );

    always_comb begin
        flen   = (r_frm.pos == 16'hFFFF) ? 16'hFFFF : r_frm.pos + 16'd1;
        head   = 16'd14 + {12'd0, r_frm.shift} + {10'd0, r_frm.hw, 2'b00};
        off    = r_frm.frag & FRAG_OFF_MSK;
        key    = {r_frm.ident, r_frm.vlan};
        c_more = (r_frm.frag & FRAG_MORE) != 16'd0;
        c_self = r_exp_en && (r_frm.dst == r_exp_ip);
        add    = (flen > head) ? flen - head : 16'd0;
        sum    = {1'b0, r_rd.len} + {1'b0, add};
        c_hit  = r_valid[r_idx] && r_rd.src == r_frm.src && r_rd.dst == r_frm.dst
                 && r_rd.key == key;
        c_last = r_idx == SLOT_W'(SLOTS - 1);
        start  = 16'd0;
        c_drop = 1'b0;
        if (r_frm.proto == PROTO_GRE) begin
            c_drop = c_self;
            start  = head + off + 16'd8;
        end
        if (r_frm.proto == PROTO_UDP) begin
            c_drop = c_self && r_frm.udp == VXLAN_PORT;
            start  = head + off + 16'd16;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (w_take && i_in.last_byte) n_state = S_READ;
            S_READ: n_state = S_CMP;
            S_CMP: begin
                if (c_hit) n_state = S_DONE;
                else if (c_last) n_state = S_MISS;
                else n_state = S_READ;
            end
            S_MISS: n_state = S_DONE;
            S_DONE: if (!o_out_valid || i_out_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        c_wr       = 1'b0;
        c_waddr    = r_idx;
        c_wdata    = r_rd;
        c_res      = '0;
        unique case (r_state)
            S_IDLE: o_in_ready = 1'b1;
            S_CMP: begin
                c_wdata.len = sum[16] ? 16'hFFFF : sum[15:0];
                c_wr        = c_hit;
                c_res.slot_index = 4'(r_idx);
                if (c_more) begin
                    c_res.verdict = VERD_APPEND;
                end else begin
                    c_res.verdict       = VERD_REASM;
                    c_res.payload_start = r_rd.start;
                    c_res.total_length  = c_wdata.len;
                end
            end
            S_MISS: begin
                c_waddr = r_free_ok ? r_free : '0;
                c_wdata = '{src: r_frm.src, dst: r_frm.dst, key: key, len: flen,
                            start: start};
                if (c_drop) begin
                    c_res.verdict = VERD_SELF;
                end else if (!c_more) begin
                    c_res.verdict      = VERD_PASS;
                    c_res.strip_offset = start;
                end else begin
                    c_wr             = 1'b1;
                    c_res.verdict    = VERD_STORED;
                    c_res.slot_index = 4'(c_waddr);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_rd <= r_mem[r_idx];
        if (c_wr) r_mem[c_waddr] <= c_wdata;
    end

    always_ff @(posedge i_clk) begin
        if (w_take && i_in.last_byte) r_frm <= w_frame;
        if (r_state == S_CMP || r_state == S_MISS) r_res <= c_res;
        if (r_state == S_DONE && (!o_out_valid || i_out_ready)) o_out <= r_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_valid     <= '0;
            r_idx       <= '0;
            r_free      <= '0;
            r_free_ok   <= 1'b0;
            o_out_valid <= 1'b0;
            r_exp_en    <= 1'b0;
            r_exp_ip    <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                if (i_cfg_index == CFG_EXPORT_EN) r_exp_en <= i_cfg_data[0];
                if (i_cfg_index == CFG_EXPORT_IP) r_exp_ip <= i_cfg_data;
            end
            if (r_state == S_IDLE) begin
                r_idx     <= '0;
                r_free_ok <= 1'b0;
            end
            if (r_state == S_CMP) begin
                if (!r_valid[r_idx] && !r_free_ok) begin
                    r_free    <= r_idx;
                    r_free_ok <= 1'b1;
                end
                if (c_hit && !c_more) r_valid[r_idx] <= 1'b0;
                if (!c_last) r_idx <= r_idx + 1'b1;
            end
            if (r_state == S_MISS && c_wr) begin
                if (!r_free_ok) r_valid[3:0] <= 4'b0001;
                else r_valid[c_waddr] <= 1'b1;
            end
            if (r_state == S_DONE && (!o_out_valid || i_out_ready)) o_out_valid <= 1'b1;
            else if (o_out_valid && i_out_ready) o_out_valid <= 1'b0;
        end
    end

endmodule

// File: rtl/core/ipftc_chk.sv
`timescale 1ns / 1ps
`include "ip_fragment_tunnel_classifier_defines.svh"
module ipftc_chk (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            i_in_valid,
    input logic            o_in_ready,
    input ipftc_pkg::t_in  i_in,
    input logic            o_out_valid,
    input logic            i_out_ready,
    input ipftc_pkg::t_out o_out
);
    import ipftc_pkg::*;

    `IPFTC_ASSERT_TOP(a_out_hold, o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out), "result changed while stalled")
    `IPFTC_ASSERT_TOP(a_last_stalls, i_in_valid && o_in_ready && i_in.last_byte |=> !o_in_ready, "byte taken during table scan")
    `IPFTC_ASSERT_TOP(a_pass_fields, o_out_valid && o_out.verdict == VERD_PASS |-> o_out.slot_index == 4'd0 && o_out.total_length == 16'd0, "pass carries slot data")
    `IPFTC_ASSERT_TOP(a_strip_only_pass, o_out_valid && o_out.verdict != VERD_PASS |-> o_out.strip_offset == 16'd0, "strip offset on non-pass")

endmodule

bind ip_fragment_tunnel_classifier ipftc_chk u_ipftc_chk (.*);
